[rtl/bspl_pkg.sv]
`default_nettype none

package bspl_pkg;

    localparam int MAX_POINTS    = 64;
    localparam int MAX_DEGREE    = 7;
    localparam int MAX_DIMENSION = 4;

    localparam int ADDR_W  = 6;
    localparam int DEG_W   = 3;
    localparam int CNT_W   = 7;
    localparam int DIM_W   = 3;
    localparam int COORD_W = 16;
    localparam int T_W     = 17;
    localparam int S_W     = 22;
    localparam int VAL_W   = 17;
    localparam int VAL_N   = MAX_DEGREE + 2;
    localparam int VIDX_W  = 4;
    localparam int KIDX_W  = 4;
    localparam int KNOT_G_W = 8;
    localparam int SPAN_W  = 4;
    localparam int RCP_W   = 27;
    localparam int RCP_SHIFT = 26;
    localparam int FRAC_W  = 16;
    localparam int MA_W    = 28;
    localparam int MB_W    = 23;
    localparam int P_W     = MA_W + MB_W;
    localparam int ACC_W   = 36;
    localparam int RND_W   = ACC_W - FRAC_W;
    localparam int WORD_W  = MAX_DIMENSION * COORD_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 2'd2;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic [CNT_W-1:0] count;
        logic [DIM_W-1:0] dim;
    } t_cfg;

    typedef struct packed {
        logic [MAX_DIMENSION-1:0][COORD_W-1:0] pos;
        logic [ADDR_W-1:0]                     first;
    } t_res;

    // Open uniform knot at local position idx of the span starting at first.
    function automatic logic [ADDR_W-1:0] knot_at(
        input logic [ADDR_W-1:0] first,
        input logic [KIDX_W-1:0] idx,
        input logic [DEG_W-1:0]  d,
        input logic [CNT_W-1:0]  q,
        input logic [ADDR_W-1:0] qmd
    );
        logic [KNOT_G_W-1:0] g;
        g = KNOT_G_W'(first) + KNOT_G_W'(1) + KNOT_G_W'(idx);
        if (g <= KNOT_G_W'(d)) begin
            return '0;
        end else if (g >= KNOT_G_W'(q)) begin
            return qmd;
        end else begin
            return ADDR_W'(g - KNOT_G_W'(d));
        end
    endfunction

    // Rounded-up reciprocal 2^26 / span; exact quotient for numerators below 2^22.
    function automatic logic [RCP_W-1:0] recip(input logic [SPAN_W-1:0] span);
        logic [RCP_W-1:0] m;
        case (span)
            4'd1:    m = RCP_W'(67108864);
            4'd2:    m = RCP_W'(33554432);
            4'd3:    m = RCP_W'(22369622);
            4'd4:    m = RCP_W'(16777216);
            4'd5:    m = RCP_W'(13421773);
            4'd6:    m = RCP_W'(11184811);
            4'd7:    m = RCP_W'(9586981);
            4'd8:    m = RCP_W'(8388608);
            4'd9:    m = RCP_W'(7456541);
            4'd10:   m = RCP_W'(6710887);
            4'd11:   m = RCP_W'(6100806);
            4'd12:   m = RCP_W'(5592406);
            4'd13:   m = RCP_W'(5162221);
            4'd14:   m = RCP_W'(4793491);
            4'd15:   m = RCP_W'(4473925);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/bspl_store.sv]
`default_nettype none

module bspl_store
    import bspl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WORD_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [0:MAX_POINTS-1];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/bspl_mul.sv]
`default_nettype none

module bspl_mul
    import bspl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic signed [MA_W-1:0] i_a,
    input  wire logic signed [MB_W-1:0] i_b,
    output logic signed      [P_W-1:0]  o_prod
);

    logic signed [P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(i_a) * P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[rtl/bspl_core.sv]
`default_nettype none

module bspl_core
    import bspl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [T_W-1:0]    i_param_t,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_res_ready,
    output logic                   o_busy,
    output logic                   o_done,
    output t_res                   o_res,
    output logic [ADDR_W-1:0]      o_rd_addr,
    input  wire logic [WORD_W-1:0] i_rd_data
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_SETUP = 13'b0000000000010,
        ST_SINIT = 13'b0000000000100,
        ST_CA    = 13'b0000000001000,
        ST_VA    = 13'b0000000010000,
        ST_CB    = 13'b0000000100000,
        ST_VB    = 13'b0000001000000,
        ST_WR    = 13'b0000010000000,
        ST_ARD   = 13'b0000100000000,
        ST_AMUL  = 13'b0001000000000,
        ST_AACC  = 13'b0010000000000,
        ST_RND   = 13'b0100000000000,
        ST_DONE  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    logic [DEG_W-1:0]  r_d;
    logic [CNT_W-1:0]  r_q;
    logic [ADDR_W-1:0] r_qmd;
    logic [DIM_W-1:0]  r_dim;
    logic [T_W-1:0]    r_t;
    logic              r_at_end;
    logic [S_W-1:0]    r_s;
    logic [ADDR_W-1:0] r_first;
    logic [DEG_W-1:0]  r_row;
    logic [DEG_W-1:0]  r_c;
    logic [DEG_W-1:0]  r_i;
    logic [1:0]        r_j;
    logic [VAL_W-1:0]  r_val [0:VAL_N-1];
    logic [VAL_W-1:0]  r_tmp;
    logic signed [ACC_W-1:0] r_acc [0:MAX_DIMENSION-1];
    t_res              r_res;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  prod;

    logic [DEG_W-1:0]  off;
    logic [KIDX_W-1:0] ia_lo, ia_hi, ib_lo, ib_hi;
    logic [ADDR_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [ADDR_W-1:0] span_a, span_b;
    logic signed [S_W:0] num_a, num_b;
    logic              ok_a, ok_b;
    logic [VAL_W-1:0]  coef;
    logic [VAL_W-1:0]  vprod;
    logic [VIDX_W-1:0] vi_c, vi_c1, vi_d, vi_i;
    logic [COORD_W-1:0] coord;
    logic [DEG_W-1:0]  qmd_new;
    logic [CNT_W-1:0]  q_new;

    bspl_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign off   = r_d - r_row;
    assign ia_lo = KIDX_W'(r_c);
    assign ia_hi = KIDX_W'(r_c) + KIDX_W'(off);
    assign ib_lo = KIDX_W'(r_c) - KIDX_W'(1);
    assign ib_hi = ib_lo + KIDX_W'(off);
    assign a_lo  = knot_at(r_first, ia_lo, r_d, r_q, r_qmd);
    assign a_hi  = knot_at(r_first, ia_hi, r_d, r_q, r_qmd);
    assign b_lo  = knot_at(r_first, ib_lo, r_d, r_q, r_qmd);
    assign b_hi  = knot_at(r_first, ib_hi, r_d, r_q, r_qmd);
    assign span_a = a_hi - a_lo;
    assign span_b = b_hi - b_lo;
    assign num_a = $signed({1'b0, a_hi, 16'b0}) - $signed({1'b0, r_s});
    assign num_b = $signed({1'b0, r_s}) - $signed({1'b0, b_lo, 16'b0});
    assign ok_a  = (r_c < r_d) && !num_a[S_W] && (num_a != '0) && (span_a != '0);
    assign ok_b  = (r_c > r_row) && !num_b[S_W] && (num_b != '0) && (span_b != '0);
    assign coef  = prod[RCP_SHIFT +: VAL_W];
    assign vprod = prod[FRAC_W +: VAL_W];
    assign vi_c  = VIDX_W'(r_c);
    assign vi_c1 = VIDX_W'(r_c) + VIDX_W'(1);
    assign vi_d  = VIDX_W'(r_d);
    assign vi_i  = VIDX_W'(r_i);
    assign coord = i_rd_data[r_j*COORD_W +: COORD_W];

    assign q_new   = i_cfg.count;
    assign qmd_new = '0;

    assign o_rd_addr = r_first + ADDR_W'(r_i);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SETUP: begin
                mul_a = MA_W'(r_qmd);
                mul_b = MB_W'(r_t);
            end
            ST_CA: begin
                if (ok_a) begin
                    mul_a = MA_W'(recip(span_a[SPAN_W-1:0]));
                    mul_b = MB_W'(num_a[S_W-1:0]);
                end
            end
            ST_VA: begin
                if (ok_a) begin
                    mul_a = MA_W'(coef);
                    mul_b = MB_W'(r_val[vi_c1]);
                end
            end
            ST_CB: begin
                if (ok_b) begin
                    mul_a = MA_W'(recip(span_b[SPAN_W-1:0]));
                    mul_b = MB_W'(num_b[S_W-1:0]);
                end
            end
            ST_VB: begin
                if (ok_b) begin
                    mul_a = MA_W'(coef);
                    mul_b = MB_W'(r_val[vi_c]);
                end
            end
            ST_AMUL: begin
                mul_a = MA_W'(r_val[vi_i]);
                mul_b = MB_W'($signed(coord));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_SINIT;
            ST_SINIT: n_state = ST_CA;
            ST_CA:    n_state = ST_VA;
            ST_VA:    n_state = ST_CB;
            ST_CB:    n_state = ST_VB;
            ST_VB:    n_state = ST_WR;
            ST_WR: begin
                if (r_c != r_d) begin
                    n_state = ST_CA;
                end else if (r_row == '0) begin
                    n_state = ST_ARD;
                end else begin
                    n_state = ST_CA;
                end
            end
            ST_ARD:   n_state = ST_AMUL;
            ST_AMUL:  n_state = ST_AACC;
            ST_AACC: begin
                if (r_j != 2'(MAX_DIMENSION - 1)) begin
                    n_state = ST_AMUL;
                end else if (r_i == r_d) begin
                    n_state = ST_RND;
                end else begin
                    n_state = ST_ARD;
                end
            end
            ST_RND:   n_state = ST_DONE;
            ST_DONE:  if (i_res_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_d      <= i_cfg.degree;
                r_q      <= q_new;
                r_qmd    <= ADDR_W'(q_new - CNT_W'(i_cfg.degree)) | ADDR_W'(qmd_new);
                r_dim    <= i_cfg.dim;
                r_at_end <= (i_param_t >= ONE_Q16);
                r_t      <= (i_param_t >= ONE_Q16) ? ONE_Q16 : i_param_t;
            end
            ST_SINIT: begin
                r_s <= prod[S_W-1:0];
                if (r_at_end) begin
                    r_first <= ADDR_W'(r_q - CNT_W'(1) - CNT_W'(r_d));
                end else begin
                    r_first <= prod[FRAC_W +: ADDR_W];
                end
                r_val[vi_d] <= ONE_Q16;
                r_row <= r_d - DEG_W'(1);
                r_c   <= r_d - DEG_W'(1);
            end
            ST_CB: begin
                r_tmp <= vprod;
            end
            ST_WR: begin
                r_val[vi_c] <= r_tmp + vprod;
                if (r_c != r_d) begin
                    r_c <= r_c + DEG_W'(1);
                end else if (r_row == '0) begin
                    r_i <= '0;
                    for (int k = 0; k < MAX_DIMENSION; k++) begin
                        r_acc[k] <= '0;
                    end
                end else begin
                    r_row <= r_row - DEG_W'(1);
                    r_c   <= r_row - DEG_W'(1);
                end
            end
            ST_ARD: begin
                r_j <= '0;
            end
            ST_AACC: begin
                r_acc[r_j] <= r_acc[r_j] + $signed(prod[ACC_W-1:0]);
                if (r_j != 2'(MAX_DIMENSION - 1)) begin
                    r_j <= r_j + 2'd1;
                end else begin
                    r_i <= r_i + DEG_W'(1);
                end
            end
            ST_RND: begin
                for (int k = 0; k < MAX_DIMENSION; k++) begin
                    logic signed [ACC_W-1:0] biased;
                    logic signed [RND_W-1:0] rounded;
                    biased  = r_acc[k] + ACC_W'(32768);
                    rounded = RND_W'(biased >>> FRAC_W);
                    if (DIM_W'(k) >= r_dim) begin
                        r_res.pos[k] <= '0;
                    end else if (rounded > RND_W'(32767)) begin
                        r_res.pos[k] <= 16'h7FFF;
                    end else if (rounded < -RND_W'(32768)) begin
                        r_res.pos[k] <= 16'h8000;
                    end else begin
                        r_res.pos[k] <= rounded[COORD_W-1:0];
                    end
                end
                r_res.first <= r_first;
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);
    assign o_res  = r_res;

endmodule

`default_nettype wire

[rtl/open_uniform_bspline_evaluator_top.sv]
// Open uniform B-spline curve evaluator.
// The input channel carries one word per item: a load word writes a control
// point of four Q8.8 coordinates into slot point_index, an evaluate word
// returns one curve point at param_t (Q1.16, values of 1.0 and above clamp
// to the curve end). The configuration channel writes degree, control count
// and dimension; its ready is always high. It must be written only while idle;
// the block itself does not enforce this. A load gives no result.
// An evaluate runs on the single shared multiplier: each basis entry steps
// through CA, VA, CB, VB and WR, each weighted control point through ARD and
// then AMUL, AACC per coordinate. Input stall is high while an evaluate runs.
// Results go through one output register; while the receiver stalls, the
// finished result waits there and the next evaluate holds in its last state.
// Reset clears the sequencer, the output valid and the configuration to
// degree 3, count 4, dimension 3; the control point store is not cleared.
`default_nettype none

module open_uniform_bspline_evaluator_top
    import bspl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_operation,
    input  wire logic [ADDR_W-1:0]    i_point_index,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    input  wire logic signed [COORD_W-1:0] i_coord_z,
    input  wire logic signed [COORD_W-1:0] i_coord_w,
    input  wire logic [T_W-1:0]       i_param_t,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [COORD_W-1:0] o_pos_x,
    output logic signed [COORD_W-1:0] o_pos_y,
    output logic signed [COORD_W-1:0] o_pos_z,
    output logic signed [COORD_W-1:0] o_pos_w,
    output logic [ADDR_W-1:0]         o_first_point,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CNT_W-1:0]     i_cfg_data
);

    logic [DEG_W-1:0] r_degree;
    logic [CNT_W-1:0] r_control_count;
    logic [DIM_W-1:0] r_dimension;
    logic             r_out_valid;
    t_res             r_out;

    t_cfg              cfg;
    t_res              core_res;
    logic              core_busy, core_done, res_ready, accept;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [DEG_W-1:0]  d_eff;
    logic [CNT_W-1:0]  q_eff;

    always_comb begin
        d_eff = (r_degree == '0) ? DEG_W'(1) : r_degree;
        q_eff = (r_control_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_control_count;
        if (q_eff < CNT_W'(d_eff) + CNT_W'(1)) begin
            q_eff = CNT_W'(d_eff) + CNT_W'(1);
        end
        cfg.degree = d_eff;
        cfg.count  = q_eff;
        if (r_dimension == '0) begin
            cfg.dim = DIM_W'(1);
        end else if (r_dimension > DIM_W'(MAX_DIMENSION)) begin
            cfg.dim = DIM_W'(MAX_DIMENSION);
        end else begin
            cfg.dim = r_dimension;
        end
    end

    assign accept    = i_valid && !o_stall;
    assign o_stall   = core_busy;
    assign res_ready = !r_out_valid || !i_stall;

    bspl_store u_store (
        .i_clk   (i_clk),
        .i_we    (accept && (i_operation == OP_LOAD)),
        .i_waddr (i_point_index),
        .i_wdata ({i_coord_w, i_coord_z, i_coord_y, i_coord_x}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    bspl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept && (i_operation == OP_EVAL)),
        .i_param_t   (i_param_t),
        .i_cfg       (cfg),
        .i_res_ready (res_ready),
        .o_busy      (core_busy),
        .o_done      (core_done),
        .o_res       (core_res),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree        <= DEG_W'(3);
            r_control_count <= CNT_W'(4);
            r_dimension     <= DIM_W'(3);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEGREE:    r_degree        <= i_cfg_data[DEG_W-1:0];
                CFG_COUNT:     r_control_count <= i_cfg_data;
                CFG_DIMENSION: r_dimension     <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_done && res_ready) begin
            r_out <= core_res;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_pos_x       = r_out.pos[0];
    assign o_pos_y       = r_out.pos[1];
    assign o_pos_z       = r_out.pos[2];
    assign o_pos_w       = r_out.pos[3];
    assign o_first_point = r_out.first;

endmodule

`default_nettype wire

[tb/bspline_checker.sv]
module bspline_checker
    import bspl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 o_stall,
    input  wire logic                 i_operation,
    input  wire logic [ADDR_W-1:0]    i_point_index,
    input  wire logic [COORD_W-1:0]   i_coord_x,
    input  wire logic [COORD_W-1:0]   i_coord_y,
    input  wire logic [COORD_W-1:0]   i_coord_z,
    input  wire logic [COORD_W-1:0]   i_coord_w,
    input  wire logic [T_W-1:0]       i_param_t,
    input  wire logic                 o_valid,
    input  wire logic                 i_stall,
    input  wire logic [COORD_W-1:0]   o_pos_x,
    input  wire logic [COORD_W-1:0]   o_pos_y,
    input  wire logic [COORD_W-1:0]   o_pos_z,
    input  wire logic [COORD_W-1:0]   o_pos_w,
    input  wire logic [ADDR_W-1:0]    o_first_point,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CNT_W-1:0]     i_cfg_data,
    output int                        o_errors,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [COORD_W-1:0] point_store [MAX_POINTS][MAX_DIMENSION];
    logic [DEG_W-1:0]   cur_degree;
    logic [CNT_W-1:0]   cur_count;
    logic [DIM_W-1:0]   cur_dim;
    t_res               curve_points_due [$];
    int                 error_count;

    assign o_errors  = error_count;
    assign o_pending = curve_points_due.size();

    function automatic longint span_coef(input longint num, input longint span);
        if (num <= 0 || span <= 0) begin
            return 0;
        end
        return num / span;
    endfunction

    function automatic t_res curve_point(input logic [T_W-1:0] t);
        t_res   r;
        longint d, q, qmd, dim, first, last, s, g, span, kn0, kn1, acc, rv;
        longint knot [2*MAX_DEGREE];
        longint val [MAX_DEGREE+1];
        int     k0i, k1i;
        d = cur_degree;
        if (d < 1) d = 1;
        if (d > MAX_DEGREE) d = MAX_DEGREE;
        q = cur_count;
        if (q > MAX_POINTS) q = MAX_POINTS;
        if (q < d + 1) q = d + 1;
        dim = cur_dim;
        if (dim < 1) dim = 1;
        if (dim > MAX_DIMENSION) dim = MAX_DIMENSION;
        qmd = q - d;
        if (t >= ONE_Q16) begin
            s = qmd * 65536;
            last = q - 1;
            first = last - d;
        end else begin
            s = qmd * longint'(t);
            first = s >>> 16;
            last = first + d;
        end
        for (int i = 0; i < 2 * d; i++) begin
            g = last + 1 - d + i;
            if (g <= d) knot[i] = 0;
            else if (g >= q) knot[i] = qmd;
            else knot[i] = g - d;
        end
        val[d] = 65536;
        for (int row = int'(d) - 1; row >= 0; row--) begin
            k0i = int'(d);
            k1i = row;
            kn0 = knot[k0i];
            kn1 = knot[k1i];
            span = kn0 - kn1;
            val[row] = (span_coef(kn0 * 65536 - s, span) * val[row+1]) >>> 16;
            for (int col = row + 1; col < d; col++) begin
                val[col] = (val[col] * span_coef(s - kn1 * 65536, span)) >>> 16;
                k0i++;
                k1i++;
                kn0 = knot[k0i];
                kn1 = knot[k1i];
                span = kn0 - kn1;
                val[col] += (span_coef(kn0 * 65536 - s, span) * val[col+1]) >>> 16;
            end
            val[d] = (val[d] * span_coef(s - kn1 * 65536, span)) >>> 16;
        end
        for (int j = 0; j < MAX_DIMENSION; j++) begin
            acc = 0;
            for (int i = 0; i <= d; i++) begin
                if (first + i >= 0 && first + i < MAX_POINTS) begin
                    acc += val[i] * longint'($signed(point_store[first+i][j]));
                end
            end
            rv = 0;
            if (j < dim) begin
                rv = (acc + 32768) >>> 16;
                if (rv > 32767) rv = 32767;
                if (rv < -32768) rv = -32768;
            end
            r.pos[j] = rv[COORD_W-1:0];
        end
        r.first = first[ADDR_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            cur_degree <= 3'd3;
            cur_count  <= 7'd4;
            cur_dim    <= 3'd3;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEGREE:    cur_degree <= i_cfg_data[DEG_W-1:0];
                    CFG_COUNT:     cur_count  <= i_cfg_data;
                    CFG_DIMENSION: cur_dim    <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                if (i_operation == OP_LOAD) begin
                    point_store[i_point_index][0] <= i_coord_x;
                    point_store[i_point_index][1] <= i_coord_y;
                    point_store[i_point_index][2] <= i_coord_z;
                    point_store[i_point_index][3] <= i_coord_w;
                end else begin
                    curve_points_due = {curve_points_due, curve_point(i_param_t)};
                end
            end
            if (o_valid && !i_stall) begin
                got.pos   = {o_pos_w, o_pos_z, o_pos_y, o_pos_x};
                got.first = o_first_point;
                if (curve_points_due.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Unexpected curve point %h", got);
                    end
                end else begin
                    want = curve_points_due.pop_front();
                    for (int j = 0; j <= MAX_DIMENSION; j++) begin
                        if (j < MAX_DIMENSION ? got.pos[j] !== want.pos[j]
                                              : got.first !== want.first) begin
                            error_count++;
                            if (error_count <= 10) begin
                                if (j < MAX_DIMENSION) begin
                                    $display("Coordinate %0d: expected %h, got %h",
                                             j, want.pos[j], got.pos[j]);
                                end else begin
                                    $display("First point: expected %0d, got %0d",
                                             want.first, got.first);
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    initial error_count = 0;

endmodule

[tb/testbench.sv]
module testbench;
    import bspl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_operation;
    logic [ADDR_W-1:0]    i_point_index;
    logic [COORD_W-1:0]   i_coord_x, i_coord_y, i_coord_z, i_coord_w;
    logic [T_W-1:0]       i_param_t;
    logic                 o_valid;
    logic                 i_stall;
    logic [COORD_W-1:0]   o_pos_x, o_pos_y, o_pos_z, o_pos_w;
    logic [ADDR_W-1:0]    o_first_point;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CNT_W-1:0]     i_cfg_data;
    int                   mismatch_count;
    int                   curve_points_pending;
    int                   cycle_count;

    open_uniform_bspline_evaluator_top u_top (.*);

    bspline_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_operation, .i_point_index,
        .i_coord_x, .i_coord_y, .i_coord_z, .i_coord_w, .i_param_t,
        .o_valid, .i_stall, .o_pos_x, .o_pos_y, .o_pos_z, .o_pos_w, .o_first_point,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(mismatch_count), .o_pending(curve_points_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [COORD_W-1:0] coord_value();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    function automatic logic [T_W-1:0] param_value();
        case ($urandom_range(0, 9))
            0:       return ONE_Q16;
            1:       return T_W'($urandom_range(65536, 131071));
            2:       return 17'd0;
            default: return T_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(input logic op, input logic [ADDR_W-1:0] slot,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic [COORD_W-1:0] w,
                             input logic [T_W-1:0] t, input bit gaps);
        int gap;
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_point_index <= slot;
        i_coord_x     <= x;
        i_coord_y     <= y;
        i_coord_z     <= z;
        i_coord_w     <= w;
        i_param_t     <= t;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        gap = gaps ? idle_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_point(input logic [ADDR_W-1:0] slot, input bit gaps);
        send_word(OP_LOAD, slot, coord_value(), coord_value(), coord_value(),
                  coord_value(), T_W'($urandom()), gaps);
    endtask

    task automatic evaluate_at(input logic [T_W-1:0] t, input bit gaps);
        send_word(OP_EVAL, ADDR_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                  COORD_W'($urandom()), COORD_W'($urandom()), t, gaps);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (curve_points_pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] deg, input logic [CNT_W-1:0] cnt,
                             input logic [CNT_W-1:0] dim, input int words);
        wait_idle();
        write_reg(CFG_DEGREE, deg);
        write_reg(CFG_COUNT, cnt);
        write_reg(CFG_DIMENSION, dim);
        write_reg(CFG_UNUSED, CNT_W'($urandom()));
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(0, 9) < 2) load_point(ADDR_W'($urandom()), 1'b1);
            else evaluate_at(param_value(), 1'b1);
        end
    endtask

    initial begin
        int len;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            len = idle_gap();
            if (len > 0) begin
                i_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("open_uniform_bspline_evaluator_top verification failed");
            $finish;
        end
    end

    initial begin
        cycle_count   = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = OP_LOAD;
        i_point_index = '0;
        i_coord_x     = '0;
        i_coord_y     = '0;
        i_coord_z     = '0;
        i_coord_w     = '0;
        i_param_t     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_DEGREE;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every slot is loaded first so that no evaluate reads an unwritten point.
        for (int p = 0; p < MAX_POINTS; p++) begin
            load_point(ADDR_W'(p), 1'b0);
        end
        send_word(OP_LOAD, 6'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, '1, 1'b0);
        send_word(OP_LOAD, 6'd2, 16'h8000, 16'h8000, 16'h8000, 16'h8000, '0, 1'b0);
        evaluate_at(17'd0, 1'b0);
        evaluate_at(17'd32768, 1'b0);
        evaluate_at(17'd65535, 1'b0);
        evaluate_at(ONE_Q16, 1'b0);
        evaluate_at(17'h1FFFF, 1'b0);
        evaluate_at(17'd1, 1'b0);

        run_phase(7'd1, 7'd2, 7'd1, 70);
        run_phase(7'd7, 7'd64, 7'd4, 70);
        run_phase(7'd0, 7'd127, 7'd0, 60);
        run_phase(7'd7, 7'd127, 7'd7, 60);
        run_phase(7'd5, 7'd3, 7'd5, 60);
        run_phase(7'd2, 7'd20, 7'd2, 80);
        run_phase(7'd3, 7'd0, 7'd3, 60);
        run_phase(7'd4, 7'd40, 7'd4, 80);
        run_phase(7'd6, 7'd65, 7'd1, 60);
        run_phase(7'd3, 7'd64, 7'd4, 100);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("open_uniform_bspline_evaluator_top verification clean");
        end else begin
            $display("open_uniform_bspline_evaluator_top verification failed");
        end
        $finish;
    end

endmodule

[open_uniform_bspline_evaluator_top.f]
rtl/bspl_pkg.sv
rtl/bspl_store.sv
rtl/bspl_mul.sv
rtl/bspl_core.sv
rtl/open_uniform_bspline_evaluator_top.sv
tb/bspline_checker.sv
tb/testbench.sv
